>>> src/descriptor_ratio_test_matcher_assert.svh
// Assertion macros for the descriptor ratio-test matcher.
// Expects clk and rst_n in the scope of every use.
`ifndef DESCRIPTOR_RATIO_TEST_MATCHER_ASSERT_SVH
`define DESCRIPTOR_RATIO_TEST_MATCHER_ASSERT_SVH

`ifndef SYNTH
`define DRTM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define DRTM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DRTM_ASSERT_IMP(lbl, ante, cons)
`define DRTM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> src/drtm_pkg.sv
// Shared types and constants for the descriptor ratio-test matcher.
// No dependencies.
`default_nettype none

package drtm_pkg;

    localparam int SUM_W           = 21;
    localparam int IDX_W           = 10;
    localparam int RATIO_W         = 9;
    localparam int MAX_ENTRIES_DEF = 1024;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd154;

    typedef struct packed {
        logic [7:0] query_byte;
        logic [7:0] list_byte;
        logic       entry_end;
        logic       list_end;
    } item_t;

    typedef struct packed {
        logic             match_found;
        logic [IDX_W-1:0] match_index;
        logic             list_overflow;
    } result_t;

endpackage

`default_nettype wire

>>> src/descriptor_ratio_test_matcher.sv
// Descriptor ratio-test matcher: one byte pair per transfer, one shared multiplier.
// Items add their square; an entry end ranks the sum; a list end runs the ratio test.
// The item is held off (stall high) until its sequence is done; the result leaves
// through an output register, so a new list may start while it waits.
// Asynchronous active-low reset clears the list state and loads ratio 154.
// Depends on drtm_pkg and descriptor_ratio_test_matcher_assert.svh.
`default_nettype none

`include "descriptor_ratio_test_matcher_assert.svh"

module descriptor_ratio_test_matcher #(
    parameter int MAX_ENTRIES = drtm_pkg::MAX_ENTRIES_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               item_valid,
    output logic                              item_stall,
    input  drtm_pkg::item_t                   item,
    output logic                              result_valid,
    input  wire                               result_stall,
    output drtm_pkg::result_t                 result,
    input  wire                               ratio_we,
    input  wire  [drtm_pkg::RATIO_W-1:0]      ratio_wdata
);
    import drtm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int MA_W   = 2 * RATIO_W;
    localparam int PROD_W = MA_W + SUM_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_R2   = 3'd3;
    localparam logic [2:0] S_RHS  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    logic [2:0]         state_reg, state_next;
    logic [7:0]         diff_reg, diff_next;
    logic               eend_reg, eend_next;
    logic               lend_reg, lend_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [SUM_W-1:0]   best_reg, best_next;
    logic [SUM_W-1:0]   second_reg, second_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               rvalid_reg, rvalid_next;
    result_t            result_reg, result_next;

    logic [MA_W-1:0]    mul_a;
    logic [SUM_W-1:0]   mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [SUM_W:0]     sum_wide;
    logic               found;

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        unique case (state_reg)
            S_SQ:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = SUM_W'(diff_reg);
            end
            S_R2:
            begin
                mul_a = MA_W'(ratio_reg);
                mul_b = SUM_W'(ratio_reg);
            end
            S_RHS:
            begin
                mul_a = prod_reg[MA_W-1:0];
                mul_b = second_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(mul_p[15:0]);
    assign found    = (cnt_reg >= CNT_W'(2)) &&
                      ({(PROD_W-SUM_W-16)'(0), best_reg, 16'd0} < prod_reg);

    always_comb
    begin
        state_next    = state_reg;
        diff_next     = diff_reg;
        eend_next     = eend_reg;
        lend_next     = lend_reg;
        ratio_next    = ratio_reg;
        sum_next      = sum_reg;
        best_next     = best_reg;
        second_next   = second_reg;
        best_idx_next = best_idx_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        prod_next     = prod_reg;
        rvalid_next   = rvalid_reg && result_stall;
        result_next   = result_reg;

        if (ratio_we)
        begin
            ratio_next = ratio_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    diff_next = (item.query_byte >= item.list_byte)
                              ? item.query_byte - item.list_byte
                              : item.list_byte - item.query_byte;
                    eend_next  = item.entry_end;
                    lend_next  = item.list_end;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                sum_next   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                state_next = (eend_reg || lend_reg) ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (cnt_reg >= CNT_W'(MAX_ENTRIES))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    if (sum_reg < best_reg)
                    begin
                        second_next   = best_reg;
                        best_next     = sum_reg;
                        best_idx_next = IDX_W'(cnt_reg);
                    end
                    else if (sum_reg < second_reg)
                    begin
                        second_next = sum_reg;
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                sum_next   = '0;
                state_next = lend_reg ? S_R2 : S_IDLE;
            end
            S_R2:
            begin
                prod_next  = mul_p;
                state_next = S_RHS;
            end
            S_RHS:
            begin
                prod_next  = mul_p;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // hold until the previous result has been taken
                if (!(rvalid_reg && result_stall))
                begin
                    rvalid_next               = 1'b1;
                    result_next.match_found   = found;
                    result_next.match_index   = found ? best_idx_reg : '0;
                    result_next.list_overflow = ovf_reg;
                    sum_next      = '0;
                    best_next     = SUM_MAX;
                    second_next   = SUM_MAX;
                    best_idx_next = '0;
                    cnt_next      = '0;
                    ovf_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ratio_reg    <= RATIO_RESET;
            sum_reg      <= '0;
            best_reg     <= SUM_MAX;
            second_reg   <= SUM_MAX;
            best_idx_reg <= '0;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            rvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ratio_reg    <= ratio_next;
            sum_reg      <= sum_next;
            best_reg     <= best_next;
            second_reg   <= second_next;
            best_idx_reg <= best_idx_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            rvalid_reg   <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg   <= diff_next;
        eend_reg   <= eend_next;
        lend_reg   <= lend_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

    `DRTM_ASSERT_IMP(a_dist_order, 1'b1, best_reg <= second_reg)
    `DRTM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_ENTRIES))
    `DRTM_ASSERT_NXT(a_item_start, item_valid && !item_stall, state_reg == S_SQ)
    `DRTM_ASSERT_IMP(a_nomatch_idx, result_valid && !result.match_found,
                     result.match_index == '0)

endmodule

`default_nettype wire

>>> tb/descriptor_ratio_test_matcher_checker.sv
`timescale 1ns / 100ps
// Checker for the descriptor ratio-test matcher: predicts each list verdict from the
// observed input transfers and ratio writes, and compares the result transfers.
// Depends on drtm_pkg.

module descriptor_ratio_test_matcher_checker
    import drtm_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    input  wire                item_stall,
    input  item_t              item,
    input  wire                result_valid,
    input  wire                result_stall,
    input  result_t            result,
    input  wire                ratio_we,
    input  wire  [RATIO_W-1:0] ratio_wdata,
    output int                 error_count,
    output int                 pending,
    output int                 result_count,
    output int                 match_count
);

    localparam int               MAX_ENTRIES = MAX_ENTRIES_DEF;
    localparam logic [SUM_W-1:0] SUM_SAT     = '1;

    logic [RATIO_W-1:0] ratio;
    logic [SUM_W-1:0]   entry_sum;
    logic [SUM_W-1:0]   best_dist;
    logic [SUM_W-1:0]   second_dist;
    logic [IDX_W-1:0]   best_idx;
    logic [IDX_W:0]     entry_count;
    logic               overflowed;
    result_t            expected_verdicts[$];

    initial
    begin
        error_count  = 0;
        pending      = 0;
        result_count = 0;
        match_count  = 0;
    end

    task automatic clear_list();
        entry_sum   = '0;
        best_dist   = SUM_SAT;
        second_dist = SUM_SAT;
        best_idx    = '0;
        entry_count = '0;
        overflowed  = 1'b0;
    endtask

    task automatic predict_verdict(input item_t it);
        logic [7:0]     diff;
        logic [SUM_W:0] square;
        logic [SUM_W:0] sum_next;
        logic [63:0]    lhs;
        logic [63:0]    rhs;
        result_t        verdict;
        diff = (it.query_byte >= it.list_byte) ? it.query_byte - it.list_byte
                                               : it.list_byte - it.query_byte;
        square   = diff * diff;
        sum_next = {1'b0, entry_sum} + square;
        entry_sum = (sum_next > {1'b0, SUM_SAT}) ? SUM_SAT : sum_next[SUM_W-1:0];
        if (it.entry_end || it.list_end)
        begin
            if (entry_count >= MAX_ENTRIES)
                overflowed = 1'b1;
            else
            begin
                if (entry_sum < best_dist)
                begin
                    second_dist = best_dist;
                    best_dist   = entry_sum;
                    best_idx    = entry_count[IDX_W-1:0];
                end
                else if (entry_sum < second_dist)
                    second_dist = entry_sum;
                entry_count = entry_count + 1'b1;
            end
            entry_sum = '0;
        end
        if (it.list_end)
        begin
            verdict = '0;
            if (entry_count >= 2)
            begin
                lhs = 64'(best_dist) << 16;
                rhs = 64'(ratio) * 64'(ratio) * 64'(second_dist);
                verdict.match_found = (lhs < rhs);
            end
            verdict.match_index   = verdict.match_found ? best_idx : '0;
            verdict.list_overflow = overflowed;
            expected_verdicts.insert(expected_verdicts.size(), verdict);
            clear_list();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            ratio = RATIO_RESET;
            clear_list();
            expected_verdicts.delete();
        end
        else
        begin
            if (ratio_we)
                ratio = ratio_wdata;
            if (item_valid && !item_stall)
                predict_verdict(item);
            if (result_valid && !result_stall)
            begin
                result_count++;
                if (result.match_found === 1'b1)
                    match_count++;
                if (expected_verdicts.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result found=%0d index=%0d overflow=%0d",
                                 $time, result.match_found, result.match_index,
                                 result.list_overflow);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result.match_found !== want.match_found
                        || result.match_index !== want.match_index
                        || result.list_overflow !== want.list_overflow)
                    begin
                        error_count++;
                        if (error_count <= 10)
                        begin
                            $display("%0t: mismatch expected found=%0d index=%0d overflow=%0d",
                                     $time, want.match_found, want.match_index,
                                     want.list_overflow);
                            $display("    got found=%0d index=%0d overflow=%0d",
                                     result.match_found, result.match_index,
                                     result.list_overflow);
                        end
                    end
                end
            end
        end
        pending = expected_verdicts.size();
    end

endmodule

>>> tb/tb_descriptor_ratio_test_matcher.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the descriptor ratio-test matcher: directed lists, random
// lists over several ratio settings, an overflowing list and a long result hold-off.
// Depends on drtm_pkg, descriptor_ratio_test_matcher and its checker.

module tb_descriptor_ratio_test_matcher;
    import drtm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DESC_BYTES  = 32;
    localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
    localparam int PHASES      = 10;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               item_valid   = 1'b0;
    logic               item_stall;
    item_t              item         = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    result_t            result;
    logic               ratio_we     = 1'b0;
    logic [RATIO_W-1:0] ratio_wdata  = '0;

    int error_count;
    int pending;
    int result_count;
    int match_count;
    int items_sent    = 0;
    int lists_sent    = 0;
    int cycles        = 0;
    int hold_requests = 0;
    int holds_done    = 0;
    bit calm_sender   = 1'b0;

    always #5 clk = ~clk;

    descriptor_ratio_test_matcher i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .ratio_we     (ratio_we),
        .ratio_wdata  (ratio_wdata)
    );

    descriptor_ratio_test_matcher_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .ratio_we     (ratio_we),
        .ratio_wdata  (ratio_wdata),
        .error_count  (error_count),
        .pending      (pending),
        .result_count (result_count),
        .match_count  (match_count)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // result side: random stall runs, calm stretches, and long hold-offs on request
    initial
    begin
        int   run_left;
        logic run_value;
        run_left  = 0;
        run_value = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                run_value = 1'b1;
                run_left  = HOLD_CYCLES;
            end
            else if (run_left == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    run_value = 1'b0;
                    run_left  = $urandom_range(20, 150);
                end
                else
                begin
                    run_value = $urandom_range(0, 1);
                    run_left  = run_value ? idle_gap() + 1 : $urandom_range(1, 4);
                end
            end
            result_stall <= run_value;
            run_left--;
        end
    end

    task automatic send_item(input logic [7:0] q, input logic [7:0] l,
                             input logic e_end, input logic l_end);
        int gap;
        item       <= {q, l, e_end, l_end};
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
        if (l_end)
            lists_sent++;
        gap = calm_sender ? 0 : idle_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_ratio(input logic [RATIO_W-1:0] value);
        ratio_we    <= 1'b1;
        ratio_wdata <= value;
        @(negedge clk);
        ratio_we    <= 1'b0;
    endtask

    task automatic send_random_list();
        logic [7:0] query_vec [0:63];
        logic [7:0] prev_vec  [0:63];
        logic [7:0] cur_vec   [0:63];
        int         n_entries;
        int         len;
        int         mode;
        int         kind;
        int         t;
        bit         saturate;
        bit         var_len;
        bit         last;
        n_entries = $urandom_range(0, 19);
        n_entries = (n_entries < 2) ? 1 : (n_entries < 4) ? $urandom_range(9, 30)
                                                          : $urandom_range(2, 8);
        mode     = $urandom_range(0, 19);
        saturate = (mode >= 18);
        var_len  = (mode < 14) && ($urandom_range(0, 3) == 0);
        if (mode < 14)
            len = $urandom_range(1, 6);
        else
        begin
            len       = saturate ? $urandom_range(DESC_BYTES + 1, DESC_BYTES + 8) : DESC_BYTES;
            n_entries = (n_entries > 3) ? 3 : n_entries;
        end
        for (int b = 0; b < 64; b++)
        begin
            query_vec[b] = saturate ? 8'hFF : 8'($urandom_range(0, 255));
            prev_vec[b]  = 8'($urandom_range(0, 255));
        end
        for (int e = 0; e < n_entries; e++)
        begin
            if (var_len)
                len = $urandom_range(1, 6);
            kind = saturate ? 9 : $urandom_range(0, 9);
            for (int b = 0; b < len; b++)
            begin
                if (kind < 3)
                begin
                    t = int'(query_vec[b]) + int'($urandom_range(0, 6)) - 3;
                    t = (t < 0) ? 0 : (t > 255) ? 255 : t;
                    cur_vec[b] = 8'(t);
                end
                else if (kind < 5)
                    cur_vec[b] = prev_vec[b];
                else if (kind < 8)
                    cur_vec[b] = 8'($urandom_range(0, 255));
                else
                    cur_vec[b] = query_vec[b][7] ? 8'h00 : 8'hFF;
            end
            last = (e == n_entries - 1);
            for (int b = 0; b < len; b++)
                send_item(query_vec[b], cur_vec[b],
                          (b == len - 1) && (!last || $urandom_range(0, 1) == 1),
                          last && (b == len - 1));
            for (int b = 0; b < len; b++)
                prev_vec[b] = cur_vec[b];
        end
    endtask

    task automatic send_noise_list();
        bit l_end;
        l_end = 1'b0;
        for (int k = 0; k < 40 && !l_end; k++)
        begin
            l_end = ($urandom_range(0, 19) == 0) || (k == 39);
            send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0, l_end);
        end
    endtask

    task automatic send_overflow_list();
        for (int e = 0; e < MAX_ENTRIES + 6; e++)
        begin
            if (e == 500 || e == MAX_ENTRIES + 3)
                send_item(8'd100, 8'd100, 1'b1, 1'b0);
            else
                send_item(8'd100, 8'($urandom_range(150, 255)), 1'b1, e == MAX_ENTRIES + 5);
        end
    endtask

    initial
    begin
        int start;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single entry: too few to match
        send_item(8'd0, 8'd255, 1'b0, 1'b1);
        // far entry then exact entry
        send_item(8'd255, 8'd0, 1'b0, 1'b0);
        send_item(8'd0, 8'd255, 1'b1, 1'b0);
        send_item(8'd128, 8'd128, 1'b0, 1'b1);
        // equal distances: first entry stays best, second equals it
        send_item(8'd10, 8'd20, 1'b1, 1'b0);
        send_item(8'd10, 8'd20, 1'b1, 1'b0);
        send_item(8'd10, 8'd20, 1'b0, 1'b1);
        // entry end and list end on the same transfer
        send_item(8'd5, 8'd5, 1'b1, 1'b0);
        send_item(8'd200, 8'd90, 1'b1, 1'b1);
        send_item(8'd255, 8'd255, 1'b1, 1'b0);
        send_item(8'd0, 8'd1, 1'b0, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       write_ratio(9'd0);
                1:       write_ratio(9'd511);
                2:       write_ratio(9'd256);
                3:       write_ratio(9'd154);
                4:       write_ratio(9'd255);
                5:       write_ratio(9'd1);
                default: write_ratio(9'($urandom_range(0, 511)));
            endcase
            if (p == 2)
            begin
                // hold results back while the sender keeps offering transfers
                hold_requests++;
                calm_sender = 1'b1;
                for (int k = 0; k < 6; k++)
                begin
                    send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b1, 1'b0);
                    send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, 1'b1);
                end
            end
            if (p == 3)
                send_overflow_list();
            start = items_sent;
            while (items_sent - start < 20)
            begin
                calm_sender = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 9) == 0)
                    send_noise_list();
                else
                    send_random_list();
            end
            calm_sender = 1'b0;
            drain();
        end

        repeat (20) @(negedge clk);
        $display("Ran %0d transfers in %0d lists over %0d ratio settings incl. 0 and 511,",
                 items_sent, lists_sent, PHASES + 1);
        $display("with an overflowing list and a long hold-off: %0d results, %0d matches.",
                 result_count, match_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> descriptor_ratio_test_matcher.f
+incdir+src
src/drtm_pkg.sv
src/descriptor_ratio_test_matcher.sv
tb/descriptor_ratio_test_matcher_checker.sv
tb/tb_descriptor_ratio_test_matcher.sv
